// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, request and status codes and cell control types for the
// double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH = 16;
	localparam int WORD_W = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int REQ_W = 2;
	localparam int STATUS_W = 2;
	localparam int ENTRY_COUNT_W = 5;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_REAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT = 2'd2;
	localparam logic [REQ_W-1:0] REQ_POP_REAR = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_REAR,
		OP_POP_FRONT,
		OP_POP_REAR
	} cell_op_t;

	// broadcast to every cell in the row
	typedef struct packed {
		cell_op_t op;
		word_t    word;
	} dq_ctl_t;

endpackage

// ===== rtl/dq_req_if.sv =====
// ----------------------------------------------------------------------------
// dq_req_if
// Request channel: operation code and word to insert.
// ----------------------------------------------------------------------------
interface dq_req_if import dq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	word_t            push_value;

	modport source (output valid, req_type, push_value, input ready);
	modport sink (input valid, req_type, push_value, output ready);
endinterface

// ===== rtl/dq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dq_rsp_if
// Response channel: popped word, status, count and current ends.
// ----------------------------------------------------------------------------
interface dq_rsp_if import dq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	word_t                    popped_value;
	logic [STATUS_W-1:0]      status;
	logic [ENTRY_COUNT_W-1:0] entry_count;
	word_t                    front_value;
	word_t                    rear_value;
	logic                     is_empty;

	modport source (output valid, popped_value, status, entry_count, front_value,
		rear_value, is_empty, input ready);
	modport sink (input valid, popped_value, status, entry_count, front_value,
		rear_value, is_empty, output ready);
endinterface

// ===== rtl/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the queue row. Words sit packed from cell 0 (front) upward;
// a cell shifts with its neighbors on front operations and acts alone at
// the rear boundary on rear operations.
// ----------------------------------------------------------------------------
module dq_cell import dq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  dq_ctl_t ctl,
	input  logic    left_valid,
	input  word_t   left_data,
	input  logic    right_valid,
	input  word_t   right_data,
	output logic    valid,
	output word_t   data,
	output logic    is_rear
);

	logic  valid_q;
	word_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_PUSH_FRONT: valid_q <= left_valid;
				OP_POP_FRONT:  valid_q <= right_valid;
				OP_PUSH_REAR: begin
					if (!valid_q && left_valid) begin
						valid_q <= 1'b1;
					end
				end
				OP_POP_REAR: begin
					if (valid_q && !right_valid) begin
						valid_q <= 1'b0;
					end
				end
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_PUSH_FRONT: data_q <= left_data;
			OP_POP_FRONT:  data_q <= right_data;
			OP_PUSH_REAR: begin
				if (!valid_q && left_valid) begin
					data_q <= ctl.word;
				end
			end
			default: data_q <= data_q;
		endcase
	end

	assign valid   = valid_q;
	assign data    = data_q;
	assign is_rear = valid_q && !right_valid;

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words held in a row of cells, with
// push and pop at either end and one response per request.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, push_value
//  rsp      out  valid/ready    popped_value, status, entry_count,
//                               front_value, rear_value, is_empty
//
// a request updates the cell row and the pending stage at its accepting edge;
// its response enters the output register when the pending stage drains
// a new request is taken every cycle while the output register drains
// if rsp stalls, one request waits between the row and the output register
// and req.ready drops until the stall clears
// reset empties the row at once; no clearing pass
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);

	dq_ctl_t ctl;
	logic [DEPTH-1:0] cell_valid;
	logic [DEPTH-1:0] cell_rear;
	word_t            cell_data [DEPTH];

	logic [CNT_W-1:0] count_q;
	logic             pend_q;
	logic [STATUS_W-1:0] status_s1;
	word_t               popped_s1;

	logic                     rsp_valid_q;
	word_t                    popped_q;
	logic [STATUS_W-1:0]      status_q;
	logic [ENTRY_COUNT_W-1:0] entry_count_q;
	word_t                    front_q;
	word_t                    rear_q;
	logic                     is_empty_q;

	logic  acc;
	logic  drain;
	logic  full;
	logic  empty;
	word_t rear_data;
	logic [STATUS_W-1:0] status_next;
	word_t               popped_next;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign drain = pend_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !pend_q || drain;
	assign acc = req.valid && req.ready;

	// the rear cell is flagged locally, so this is a one-hot select
	always_comb begin
		rear_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_data = rear_data | (cell_data[i] & {WORD_W{cell_rear[i]}});
		end
	end

	always_comb begin
		ctl.op      = OP_HOLD;
		ctl.word    = req.push_value;
		status_next = ST_OK;
		popped_next = '0;
		unique case (req.req_type)
			REQ_PUSH_FRONT: begin
				if (full) begin
					status_next = ST_FULL;
				end else if (acc) begin
					ctl.op = OP_PUSH_FRONT;
				end
			end
			REQ_PUSH_REAR: begin
				if (full) begin
					status_next = ST_FULL;
				end else if (acc) begin
					ctl.op = OP_PUSH_REAR;
				end
			end
			REQ_POP_FRONT: begin
				if (empty) begin
					status_next = ST_EMPTY;
				end else begin
					popped_next = cell_data[0];
					if (acc) begin
						ctl.op = OP_POP_FRONT;
					end
				end
			end
			REQ_POP_REAR: begin
				if (empty) begin
					status_next = ST_EMPTY;
				end else begin
					popped_next = rear_data;
					if (acc) begin
						ctl.op = OP_POP_REAR;
					end
				end
			end
		endcase
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic  left_valid;
		word_t left_data;
		logic  right_valid;
		word_t right_data;

		if (g == 0) begin : g_first
			assign left_valid = 1'b1;
			assign left_data  = req.push_value;
		end else begin : g_mid_l
			assign left_valid = cell_valid[g-1];
			assign left_data  = cell_data[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_valid = 1'b0;
			assign right_data  = '0;
		end else begin : g_mid_r
			assign right_valid = cell_valid[g+1];
			assign right_data  = cell_data[g+1];
		end

		dq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_valid  (left_valid),
			.left_data   (left_data),
			.right_valid (right_valid),
			.right_data  (right_data),
			.valid       (cell_valid[g]),
			.data        (cell_data[g]),
			.is_rear     (cell_rear[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.op == OP_PUSH_FRONT || ctl.op == OP_PUSH_REAR) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.op == OP_POP_FRONT || ctl.op == OP_POP_REAR) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (acc) begin
				pend_q <= 1'b1;
			end else if (drain) begin
				pend_q <= 1'b0;
			end
			if (drain) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_next;
			popped_s1 <= popped_next;
		end
		// the row already holds the state after the pending transaction
		if (drain) begin
			popped_q      <= popped_s1;
			status_q      <= status_s1;
			entry_count_q <= ENTRY_COUNT_W'(count_q);
			front_q       <= cell_valid[0] ? cell_data[0] : '0;
			rear_q        <= rear_data;
			is_empty_q    <= empty;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.status       = status_q;
	assign rsp.entry_count  = entry_count_q;
	assign rsp.front_value  = front_q;
	assign rsp.rear_value   = rear_q;
	assign rsp.is_empty     = is_empty_q;

	a_count_matches_row: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("count disagrees with occupied cells");

	a_single_rear: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_rear) && ((cell_rear == '0) == empty))
		else $error("rear flag not unique");

	a_full_push_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		acc && full && (req.req_type == REQ_PUSH_FRONT || req.req_type == REQ_PUSH_REAR)
		|=> $stable(count_q) && $stable(cell_valid))
		else $error("rejected push changed the row");

	a_accept_pends: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> pend_q)
		else $error("accepted transaction lost");

endmodule
